>>> src/gam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gam_pkg;

  // command codes
  localparam logic [1:0] CMD_ADD_VERTEX = 2'd0;
  localparam logic [1:0] CMD_REM_VERTEX = 2'd1;
  localparam logic [1:0] CMD_ADD_EDGE   = 2'd2;
  localparam logic [1:0] CMD_REM_EDGE   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_BAD_EDGE  = 2'd3;

  // read address select
  localparam logic [1:0] RSEL_A     = 2'd0;
  localparam logic [1:0] RSEL_B     = 2'd1;
  localparam logic [1:0] RSEL_SWEEP = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       add_vertex;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       edge_wr_a;
    logic       edge_wr_b;
    logic       sweep_init;
    logic       sweep_step;
    logic       sweep_flush;
    logic       count_dec;
    logic       out_load;
  } gam_ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] status;
    logic       single;
    logic       sweep_last;
    logic       out_free;
  } gam_stat_t;

endpackage

`default_nettype wire

>>> src/gam_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module gam_datapath #(
  parameter int MAX_VERTICES = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  gam_pkg::gam_ctrl_t    ctrl,
  output gam_pkg::gam_stat_t    stat,
  input  wire  [1:0]            in_cmd,
  input  wire  signed [31:0]    in_vertex_value,
  input  wire  [5:0]            in_index_a,
  input  wire  [5:0]            in_index_b,
  input  wire                   out_tready,
  output logic                  out_tvalid,
  output logic [1:0]            out_status,
  output logic [6:0]            out_vertex_count,
  output logic signed [31:0]    out_read_value,
  output logic [31:0]           out_read_row
);

  localparam int RW = MAX_VERTICES;
  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // captured command
  logic [1:0]         cmd_r;
  logic signed [31:0] val_r;
  logic [5:0]         a_r;
  logic [5:0]         b_r;
  logic [1:0]         status_r;
  logic [1:0]         status_nxt;
  logic [CW-1:0]      count_r;

  // sweep state
  logic [IW-1:0]      k_r;
  logic [IW-1:0]      wk_r;
  logic               wr_pend_r;

  // memories
  logic [RW-1:0]      adj_mem [MAX_VERTICES];
  logic [31:0]        val_mem [MAX_VERTICES];
  logic [RW-1:0]      rd_row_r;
  logic [31:0]        rd_val_r;

  logic [IW-1:0]      a_idx;
  logic [IW-1:0]      b_idx;
  logic [IW-1:0]      cnt_idx;
  logic [IW-1:0]      src_idx;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [RW-1:0]      wr_row;
  logic               vwr_en;
  logic [IW-1:0]      vwr_addr;
  logic [31:0]        vwr_data;
  logic [RW-1:0]      bit_a;
  logic [RW-1:0]      bit_b;
  logic [RW-1:0]      mask_lo;
  logic [RW-1:0]      dropped;
  logic [CW:0]        k_plus2;
  logic [6:0]         count_ext;
  logic               in_rng;
  logic [63:0]        row_wide;

  logic               out_tvalid_r;
  logic [1:0]         out_status_r;
  logic [6:0]         out_count_r;
  logic signed [31:0] out_value_r;
  logic [31:0]        out_row_r;

  assign a_idx     = a_r[IW-1:0];
  assign b_idx     = b_r[IW-1:0];
  assign cnt_idx   = count_r[IW-1:0];
  assign count_ext = 7'(count_r);
  assign src_idx   = (k_r < a_idx) ? k_r : (k_r + IW'(1));
  assign bit_a     = RW'(1) << a_idx;
  assign bit_b     = RW'(1) << b_idx;
  assign mask_lo   = bit_a - RW'(1);
  // delete column a: bits below a stay, bits above move down one place
  assign dropped   = (rd_row_r & mask_lo) | ((rd_row_r >> 1) & ~mask_lo);
  assign k_plus2   = (CW+1)'(k_r) + (CW+1)'(2);

  // status of an incoming command against the current count
  always_comb begin
    status_nxt = gam_pkg::ST_OK;
    case (in_cmd)
      gam_pkg::CMD_ADD_VERTEX: begin
        if (count_ext >= 7'(MAX_VERTICES)) status_nxt = gam_pkg::ST_FULL;
      end
      gam_pkg::CMD_REM_VERTEX: begin
        if (7'(in_index_a) >= count_ext) status_nxt = gam_pkg::ST_RANGE;
      end
      default: begin
        if (7'(in_index_a) >= count_ext || 7'(in_index_b) >= count_ext ||
            in_index_a == in_index_b)
          status_nxt = gam_pkg::ST_BAD_EDGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r    <= in_cmd;
      val_r    <= in_vertex_value;
      a_r      <= in_index_a;
      b_r      <= in_index_b;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.add_vertex) begin
      count_r <= count_r + CW'(1);
    end else if (ctrl.count_dec) begin
      count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else if (ctrl.sweep_step) begin
      wr_pend_r <= 1'b1;
    end else if (ctrl.sweep_flush) begin
      wr_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sweep_init) begin
      k_r <= '0;
    end else if (ctrl.sweep_step) begin
      k_r  <= k_r + IW'(1);
      wk_r <= k_r;
    end
  end

  always_comb begin
    case (ctrl.rd_sel)
      gam_pkg::RSEL_A:     rd_addr = a_idx;
      gam_pkg::RSEL_B:     rd_addr = b_idx;
      gam_pkg::RSEL_SWEEP: rd_addr = src_idx;
      default:             rd_addr = a_idx;
    endcase
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = a_idx;
    wr_row   = '0;
    vwr_en   = 1'b0;
    vwr_addr = cnt_idx;
    vwr_data = val_r;
    if (ctrl.add_vertex) begin
      wr_en    = 1'b1;
      wr_addr  = cnt_idx;
      wr_row   = '0;
      vwr_en   = 1'b1;
    end else if (ctrl.edge_wr_a) begin
      wr_en    = 1'b1;
      wr_addr  = a_idx;
      wr_row   = (cmd_r == gam_pkg::CMD_ADD_EDGE) ? (rd_row_r | bit_b) : (rd_row_r & ~bit_b);
    end else if (ctrl.edge_wr_b) begin
      wr_en    = 1'b1;
      wr_addr  = b_idx;
      wr_row   = (cmd_r == gam_pkg::CMD_ADD_EDGE) ? (rd_row_r | bit_a) : (rd_row_r & ~bit_a);
    end else if (wr_pend_r) begin
      wr_en    = 1'b1;
      wr_addr  = wk_r;
      wr_row   = dropped;
      vwr_en   = 1'b1;
      vwr_addr = wk_r;
      vwr_data = rd_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) adj_mem[wr_addr] <= wr_row;
    if (ctrl.rd_en) rd_row_r <= adj_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vwr_en) val_mem[vwr_addr] <= vwr_data;
    if (ctrl.rd_en) rd_val_r <= val_mem[rd_addr];
  end

  assign in_rng   = 7'(a_r) < count_ext;
  assign row_wide = 64'(rd_row_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_status_r <= status_r;
      out_count_r  <= count_ext;
      out_value_r  <= in_rng ? rd_val_r : 32'sd0;
      out_row_r    <= in_rng ? row_wide[31:0] : 32'd0;
    end
  end

  assign stat.cmd        = cmd_r;
  assign stat.status     = status_r;
  assign stat.single     = (count_r == CW'(1));
  assign stat.sweep_last = (k_plus2 == (CW+1)'(count_r));
  assign stat.out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid       = out_tvalid_r;
  assign out_status       = out_status_r;
  assign out_vertex_count = out_count_r;
  assign out_read_value   = out_value_r;
  assign out_read_row     = out_row_r;

endmodule

`default_nettype wire

>>> src/gam_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module gam_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  gam_pkg::gam_stat_t   stat,
  output gam_pkg::gam_ctrl_t   ctrl
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_EXEC      = 3'd1;
  localparam logic [2:0] S_EDGE_WA   = 3'd2;
  localparam logic [2:0] S_EDGE_WB   = 3'd3;
  localparam logic [2:0] S_SWEEP     = 3'd4;
  localparam logic [2:0] S_SWEEP_END = 3'd5;
  localparam logic [2:0] S_RB_ADDR   = 3'd6;
  localparam logic [2:0] S_RB_DATA   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    ctrl.rd_sel = gam_pkg::RSEL_A;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctrl.capture = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.status != gam_pkg::ST_OK) begin
          state_nxt = S_RB_ADDR;
        end else begin
          case (stat.cmd)
            gam_pkg::CMD_ADD_VERTEX: begin
              ctrl.add_vertex = 1'b1;
              state_nxt       = S_RB_ADDR;
            end
            gam_pkg::CMD_REM_VERTEX: begin
              ctrl.sweep_init = 1'b1;
              if (stat.single) begin
                ctrl.count_dec = 1'b1;
                state_nxt      = S_RB_ADDR;
              end else begin
                state_nxt = S_SWEEP;
              end
            end
            default: begin
              ctrl.rd_en  = 1'b1;
              ctrl.rd_sel = gam_pkg::RSEL_A;
              state_nxt   = S_EDGE_WA;
            end
          endcase
        end
      end
      S_EDGE_WA: begin
        ctrl.edge_wr_a = 1'b1;
        ctrl.rd_en     = 1'b1;
        ctrl.rd_sel    = gam_pkg::RSEL_B;
        state_nxt      = S_EDGE_WB;
      end
      S_EDGE_WB: begin
        ctrl.edge_wr_b = 1'b1;
        state_nxt      = S_RB_ADDR;
      end
      S_SWEEP: begin
        ctrl.rd_en      = 1'b1;
        ctrl.rd_sel     = gam_pkg::RSEL_SWEEP;
        ctrl.sweep_step = 1'b1;
        if (stat.sweep_last) state_nxt = S_SWEEP_END;
      end
      S_SWEEP_END: begin
        ctrl.sweep_flush = 1'b1;
        ctrl.count_dec   = 1'b1;
        state_nxt        = S_RB_ADDR;
      end
      S_RB_ADDR: begin
        ctrl.rd_en  = 1'b1;
        ctrl.rd_sel = gam_pkg::RSEL_A;
        state_nxt   = S_RB_DATA;
      end
      S_RB_DATA: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/graph_adjacency_matrix_store.sv
// command flow: add vertex and refused commands pass the exec and readback states, edge
// commands also both edge write states, remove vertex also the row sweep (skipped when it
// removes the only vertex) that compacts the matrix with one read-modify-write per cycle
// ordering: one command at a time, the next beat is taken in the cycle after the result
// is loaded into the output register
// reset: sync active low, clears state, count and output valid; each new vertex zeroes its row
`timescale 1ns / 1ps
`default_nettype none

module graph_adjacency_matrix_store #(
  parameter int MAX_VERTICES = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  // command channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,    // cmd[1:0], vertex_value[33:2], index_a[39:34],
                                   // index_b[45:40], zero pad
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [79:0] out_tdata    // status[1:0], vertex_count[8:2], read_value[40:9],
                                   // read_row[72:41], zero pad
);

  gam_pkg::gam_ctrl_t ctrl;
  gam_pkg::gam_stat_t stat;

  // unpacked command fields
  logic [1:0]         in_cmd;
  logic signed [31:0] in_vertex_value;
  logic [5:0]         in_index_a;
  logic [5:0]         in_index_b;

  // result fields before packing
  logic [1:0]         out_status;
  logic [6:0]         out_vertex_count;
  logic signed [31:0] out_read_value;
  logic [31:0]        out_read_row;

  assign in_cmd          = in_tdata[1:0];
  assign in_vertex_value = in_tdata[33:2];
  assign in_index_a      = in_tdata[39:34];
  assign in_index_b      = in_tdata[45:40];

  // sequencer: walks each command through its memory accesses
  gam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // memories, vertex count, sweep counters and the output register
  gam_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_cmd           (in_cmd),
    .in_vertex_value  (in_vertex_value),
    .in_index_a       (in_index_a),
    .in_index_b       (in_index_b),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .out_status       (out_status),
    .out_vertex_count (out_vertex_count),
    .out_read_value   (out_read_value),
    .out_read_row     (out_read_row)
  );

  // pack result fields, lowest field first
  assign out_tdata = {7'd0, out_read_row, out_read_value, out_vertex_count, out_status};

endmodule

`default_nettype wire

>>> tb/tb_graph_adjacency_matrix_store.sv
`timescale 1ns / 1ps

module tb_graph_adjacency_matrix_store;

  localparam int MAXV        = 32;
  localparam int RAND_ITEMS  = 1950;
  localparam int IDLE_LIMIT  = 3000;   // cycles with no beat on either side
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int HOLD_AT     = 600;    // accepted commands before the hold-off
  localparam int TAIL_CYCLES = 40;     // longest remove grows with the vertex count

  // command mix of one stretch of random traffic
  typedef enum int {SEG_GROW, SEG_SHRINK, SEG_EDGES, SEG_NOISE} seg_kind_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] value;
    logic [5:0]  idx_a;
    logic [5:0]  idx_b;
    bit          wait_idle;   // hold this beat until nothing is outstanding
  } graph_cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [6:0]  count;
    logic [31:0] value;
    logic [31:0] row;
  } graph_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [47:0] in_tdata = '0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [79:0] out_tdata;

  graph_adjacency_matrix_store #(.MAX_VERTICES(MAXV)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #2 clk = ~clk;

  // planned commands and results still owed by the block
  graph_cmd_t    cmd_plan[$];
  graph_result_t expected_results[$];
  int unsigned   next_idx = 0;
  int unsigned   cmds_taken = 0;
  int unsigned   mismatches = 0;
  int unsigned   idle_cycles = 0;
  bit            took_in = 1'b0;

  // shadow of the graph held by the block
  logic [31:0]   shadow_vals[MAXV];
  logic [63:0]   shadow_rows[MAXV];
  int unsigned   shadow_count = 0;

  // one command against the shadow graph, queues the result it must produce
  task automatic graph_step(input logic [1:0] cmd, input logic [31:0] value,
                            input logic [5:0] a, input logic [5:0] b);
    graph_result_t res;
    int unsigned   n;
    logic [63:0]   low_mask;
    n = shadow_count;
    res.status = gam_pkg::ST_OK;
    case (cmd)
      gam_pkg::CMD_ADD_VERTEX: begin
        if (n >= MAXV) begin
          res.status = gam_pkg::ST_FULL;
        end else begin
          shadow_vals[n] = value;
          shadow_rows[n] = '0;
          for (int i = 0; i < n; i++) shadow_rows[i][n] = 1'b0;
          shadow_count = n + 1;
        end
      end
      gam_pkg::CMD_REM_VERTEX: begin
        if (a >= n) begin
          res.status = gam_pkg::ST_RANGE;
        end else begin
          // close the gap in the value list and the row list
          for (int i = a; i + 1 < n; i++) begin
            shadow_vals[i] = shadow_vals[i + 1];
            shadow_rows[i] = shadow_rows[i + 1];
          end
          shadow_rows[n - 1] = '0;
          shadow_vals[n - 1] = '0;
          // then squeeze column a out of every remaining row
          low_mask = (64'd1 << a) - 64'd1;
          for (int i = 0; i + 1 < n; i++)
            shadow_rows[i] = (shadow_rows[i] & low_mask) |
                             ((shadow_rows[i] >> (a + 1)) << a);
          shadow_count = n - 1;
        end
      end
      default: begin
        if (a >= n || b >= n || a == b) begin
          res.status = gam_pkg::ST_BAD_EDGE;
        end else begin
          // both symmetric bits move together
          shadow_rows[a][b] = (cmd == gam_pkg::CMD_ADD_EDGE);
          shadow_rows[b][a] = (cmd == gam_pkg::CMD_ADD_EDGE);
        end
      end
    endcase
    res.count = shadow_count[6:0];
    // readback of index_a after the step, zero when out of range
    if (a < shadow_count) begin
      res.value = shadow_vals[a];
      res.row   = shadow_rows[a][31:0];
    end else begin
      res.value = '0;
      res.row   = '0;
    end
    expected_results.push_back(res);
  endtask

  // rising edge: take accepted beats, predict, check results
  always @(posedge clk) begin
    graph_result_t want;
    logic [1:0]    got_status;
    logic [6:0]    got_count;
    logic [31:0]   got_value;
    logic [31:0]   got_row;
    took_in = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      graph_step(in_tdata[1:0], in_tdata[33:2], in_tdata[39:34], in_tdata[45:40]);
      next_idx++;
      cmds_taken++;
      took_in = 1'b1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_status = out_tdata[1:0];
      got_count  = out_tdata[8:2];
      got_value  = out_tdata[40:9];
      got_row    = out_tdata[72:41];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d count %0d value %h row %h",
                   got_status, got_count, got_value, got_row);
      end else begin
        want = expected_results.pop_front();
        if (got_status !== want.status || got_count !== want.count ||
            got_value !== want.value || got_row !== want.row) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch at %0t: exp status %0d count %0d value %h row %h,",
                      " got status %0d count %0d value %h row %h"},
                     $realtime, want.status, want.count, want.value, want.row,
                     got_status, got_count, got_value, got_row);
        end
      end
    end
  end

  // watchdog: no beat on either side for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_graph_adjacency_matrix_store failed");
      $finish;
    end
  end

  // command driver: bursts of beats with random gaps, valid held until taken
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    bit offer;
    offer = 1'b0;
    if (rst_n && !(in_tvalid && !took_in)) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (next_idx < cmd_plan.size() &&
                   (!cmd_plan[next_idx].wait_idle || expected_results.size() == 0)) begin
        offer = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          // a third of the gaps are zero so some stretches run back to back
          if ($urandom_range(0, 2) == 0)
            gap_left = 0;
          else
            gap_left = $urandom_range(1, $urandom_range(0, 1) ? 6 : 40);
        end
      end
      in_tvalid <= offer;
      if (offer)
        in_tdata <= {2'b00, cmd_plan[next_idx].idx_b, cmd_plan[next_idx].idx_a,
                     cmd_plan[next_idx].value, cmd_plan[next_idx].cmd};
    end
  end

  // result receiver: its own stall modes plus one long hold-off
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned rx_mode = 0;
  int unsigned mode_left = 0;
  int unsigned stall_run = 0;

  always @(negedge clk) begin
    logic ready;
    ready = 1'b1;
    if (rst_n) begin
      if (!hold_done && cmds_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0: ready = 1'b1;
          1: ready = 1'($urandom_range(0, 1));
          default: begin
            // runs of stall cycles between single ready cycles
            if (stall_run > 0) begin
              stall_run--;
              ready = 1'b0;
            end else begin
              stall_run = $urandom_range(0, 20);
              ready = 1'b1;
            end
          end
        endcase
      end
      out_tready <= ready;
    end
  end

  // index in range most of the time, anything 0..63 otherwise
  function automatic logic [5:0] pick_index(int unsigned n);
    if (n == 0 || $urandom_range(0, 9) == 0)
      return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic plan_cmd(input logic [1:0] cmd, input logic [31:0] value,
                          input logic [5:0] a, input logic [5:0] b, input bit hold);
    graph_cmd_t c;
    c.cmd = cmd;
    c.value = value;
    c.idx_a = a;
    c.idx_b = b;
    c.wait_idle = hold;
    cmd_plan.push_back(c);
  endtask

  initial begin
    seg_kind_t   seg;
    int unsigned seg_len;
    int unsigned gen_n;
    int unsigned r;
    logic [1:0]  op;
    logic [5:0]  a;
    logic [5:0]  b;

    // directed: empty graph refusals, extreme values, edge cases, removals
    plan_cmd(gam_pkg::CMD_REM_VERTEX, '0, 6'd0, 6'd0, 1'b0);      // remove from empty graph
    plan_cmd(gam_pkg::CMD_ADD_EDGE, '0, 6'd0, 6'd1, 1'b0);        // edge in empty graph
    plan_cmd(gam_pkg::CMD_ADD_VERTEX, 32'h8000_0000, 6'd0, 6'd63, 1'b0);
    plan_cmd(gam_pkg::CMD_ADD_VERTEX, 32'h7fff_ffff, 6'd1, 6'd0, 1'b0);
    plan_cmd(gam_pkg::CMD_ADD_VERTEX, 32'hffff_ffff, 6'd63, 6'd0, 1'b0); // readback past count
    plan_cmd(gam_pkg::CMD_ADD_VERTEX, 32'h0000_0000, 6'd3, 6'd0, 1'b0);
    plan_cmd(gam_pkg::CMD_ADD_EDGE, '1, 6'd0, 6'd1, 1'b0);
    plan_cmd(gam_pkg::CMD_ADD_EDGE, '0, 6'd3, 6'd0, 1'b0);
    plan_cmd(gam_pkg::CMD_ADD_EDGE, '0, 6'd1, 6'd3, 1'b0);
    plan_cmd(gam_pkg::CMD_ADD_EDGE, '0, 6'd2, 6'd3, 1'b0);
    plan_cmd(gam_pkg::CMD_ADD_EDGE, '0, 6'd1, 6'd1, 1'b0);        // equal ends
    plan_cmd(gam_pkg::CMD_ADD_EDGE, '0, 6'd2, 6'd63, 1'b0);       // end out of range
    plan_cmd(gam_pkg::CMD_REM_EDGE, '0, 6'd63, 6'd0, 1'b0);       // end out of range
    plan_cmd(gam_pkg::CMD_REM_EDGE, '0, 6'd2, 6'd2, 1'b0);        // equal ends
    plan_cmd(gam_pkg::CMD_REM_EDGE, '0, 6'd1, 6'd0, 1'b0);
    plan_cmd(gam_pkg::CMD_REM_EDGE, '0, 6'd1, 6'd0, 1'b0);        // already clear
    plan_cmd(gam_pkg::CMD_REM_VERTEX, '0, 6'd4, 6'd0, 1'b0);      // index equal to count
    plan_cmd(gam_pkg::CMD_REM_VERTEX, '0, 6'd63, 6'd63, 1'b0);
    plan_cmd(gam_pkg::CMD_REM_VERTEX, '0, 6'd1, 6'd0, 1'b0);      // middle vertex with edges
    plan_cmd(gam_pkg::CMD_REM_VERTEX, '0, 6'd2, 6'd0, 1'b0);      // last vertex
    plan_cmd(gam_pkg::CMD_REM_VERTEX, '0, 6'd0, 6'd0, 1'b0);
    plan_cmd(gam_pkg::CMD_REM_VERTEX, '0, 6'd0, 6'd0, 1'b0);      // graph empty again
    gen_n = 0;

    // random traffic in stretches that grow, shrink or churn the graph,
    // grow stretches run into the full graph now and then
    while (cmd_plan.size() < 22 + RAND_ITEMS) begin
      seg     = seg_kind_t'($urandom_range(0, 3));
      seg_len = $urandom_range(8, 60);
      repeat (seg_len) begin
        r = $urandom_range(0, 99);
        case (seg)
          SEG_GROW:
            op = r < 70 ? gam_pkg::CMD_ADD_VERTEX : r < 82 ? gam_pkg::CMD_ADD_EDGE :
                 r < 92 ? gam_pkg::CMD_REM_EDGE : gam_pkg::CMD_REM_VERTEX;
          SEG_SHRINK:
            op = r < 55 ? gam_pkg::CMD_REM_VERTEX : r < 70 ? gam_pkg::CMD_ADD_VERTEX :
                 r < 85 ? gam_pkg::CMD_ADD_EDGE : gam_pkg::CMD_REM_EDGE;
          SEG_EDGES:
            op = r < 45 ? gam_pkg::CMD_ADD_EDGE : r < 80 ? gam_pkg::CMD_REM_EDGE :
                 r < 90 ? gam_pkg::CMD_ADD_VERTEX : gam_pkg::CMD_REM_VERTEX;
          default:
            op = 2'($urandom_range(0, 3));
        endcase
        if (seg == SEG_NOISE) begin
          a = 6'($urandom_range(0, 63));
          b = 6'($urandom_range(0, 63));
        end else begin
          a = pick_index(gen_n);
          b = pick_index(gen_n);
          if ($urandom_range(0, 19) == 0) b = a;
        end
        // add vertex reads back mostly the new vertex
        if (op == gam_pkg::CMD_ADD_VERTEX && seg != SEG_NOISE && $urandom_range(0, 1))
          a = gen_n[5:0];
        plan_cmd(op, pick_value(), a, b, 1'b0);
        if (op == gam_pkg::CMD_ADD_VERTEX && gen_n < MAXV) gen_n++;
        if (op == gam_pkg::CMD_REM_VERTEX && a < gen_n) gen_n--;
      end
    end
    // sender waits for the block to drain before these beats
    cmd_plan[22].wait_idle = 1'b1;
    cmd_plan[1000].wait_idle = 1'b1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (next_idx < cmd_plan.size() || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("tb_graph_adjacency_matrix_store passed");
    else
      $display("tb_graph_adjacency_matrix_store failed");
    $finish;
  end

endmodule

>>> files.f
src/gam_pkg.sv
src/gam_datapath.sv
src/gam_ctrl.sv
src/graph_adjacency_matrix_store.sv
tb/tb_graph_adjacency_matrix_store.sv
